// ----- hw/rtl/tcpu_pkg.sv -----
// Shared types, codes and sizes for the toy CPU execute unit.
`timescale 1ns / 1ps
`default_nettype none
package tcpu_pkg;

  // Data and stream widths.
  localparam int DATA_W        = 16;
  localparam int MEM_WORDS_DEF = 2048;
  localparam int IN_TDATA_W    = 48;
  localparam int OUT_TDATA_W   = 24;

  // Command codes.
  localparam logic [3:0] CMD_MOV  = 4'd0;
  localparam logic [3:0] CMD_ADD  = 4'd1;
  localparam logic [3:0] CMD_MUL  = 4'd2;
  localparam logic [3:0] CMD_SUB  = 4'd3;
  localparam logic [3:0] CMD_DIV  = 4'd4;
  localparam logic [3:0] CMD_AND  = 4'd5;
  localparam logic [3:0] CMD_OR   = 4'd6;
  localparam logic [3:0] CMD_XOR  = 4'd7;
  localparam logic [3:0] CMD_BZ   = 4'd8;
  localparam logic [3:0] CMD_BNZ  = 4'd9;
  localparam logic [3:0] CMD_BNEG = 4'd10;
  localparam logic [3:0] CMD_BPOS = 4'd11;

  // Destination kinds; the fourth code acts as indirect.
  localparam logic [1:0] DK_REG = 2'd0;
  localparam logic [1:0] DK_DIR = 2'd1;
  localparam logic [1:0] DK_IND = 2'd2;

  // Source kinds.
  localparam logic [1:0] SK_IMM = 2'd0;
  localparam logic [1:0] SK_REG = 2'd1;
  localparam logic [1:0] SK_DIR = 2'd2;
  localparam logic [1:0] SK_IND = 2'd3;

  // Error codes.
  localparam logic [1:0] ERR_OK   = 2'd0;
  localparam logic [1:0] ERR_ADDR = 2'd1;
  localparam logic [1:0] ERR_DIV0 = 2'd2;

  // Data memory read address source.
  typedef enum logic [1:0] {
    RD_DADDR,
    RD_SADDR,
    RD_PTR
  } rd_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load_item;
    logic       clr_we;
    logic       rd_en;
    rd_sel_t    rd_sel;
    logic       dval_ld_reg;
    logic       dval_ld_mem;
    logic       dloc_ld_daddr;
    logic       dloc_ld_ptr;
    logic       sval_ld_src;
    logic       sval_ld_mem;
    logic       err_set;
    logic [1:0] err_code;
    logic       alu_go;
    logic       div_start;
    logic       div_step;
    logic       div_fix;
    logic       commit;
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic       is_branch;
    logic       is_xor;
    logic       is_div;
    logic [1:0] dkind;
    logic [1:0] skind;
    logic       daddr_bad;
    logic       saddr_bad;
    logic       ptr_bad;
    logic       src_zero;
    logic       div_last;
    logic       clr_last;
    logic       out_free;
  } sts_t;

endpackage
`default_nettype wire

// ----- hw/rtl/toy_cpu_execute_unit.sv -----
// Top level of the toy CPU execute unit: controller plus datapath.
`timescale 1ns / 1ps
`default_nettype none
// Executes one decoded instruction per input transaction on four 16-bit
// registers and a MEM_WORDS-word data memory, returning one result per
// instruction. After reset the unit clears the data memory one word per
// cycle, with in_tready low. Instructions then run one at a time through a
// sequencer: each direct memory operand adds one read and each indirect one
// two reads, all through the single registered read port of the data memory,
// and a divide runs a bit-serial divider. The result register lets the next
// instruction be accepted while a result waits for out_tready.
module toy_cpu_execute_unit #(
  parameter int MEM_WORDS = tcpu_pkg::MEM_WORDS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // command[3:0], dest_kind[5:4], dest_reg[7:6], dest_addr[18:8],
  // src_kind[20:19], src_reg[22:21], src_addr[33:23], src_imm[41:34]
  input  wire logic [tcpu_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // result_value[15:0], branch_taken[16], error_code[18:17]
  output logic      [tcpu_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import tcpu_pkg::*;

  ctl_t ctl;
  sts_t sts;

  tcpu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .ctl       (ctl)
  );

  tcpu_dpath #(
    .MEM_WORDS (MEM_WORDS)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata)
  );

endmodule
`default_nettype wire

// ----- hw/rtl/tcpu_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module tcpu_ram #(
  parameter int WIDTH = tcpu_pkg::DATA_W,
  parameter int DEPTH = tcpu_pkg::MEM_WORDS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/tcpu_ctrl.sv -----
// Controller state machine that sequences fetch, execute and write-back.
`timescale 1ns / 1ps
`default_nettype none
module tcpu_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_tvalid,
  output logic                in_tready,
  input  wire tcpu_pkg::sts_t sts,
  output tcpu_pkg::ctl_t      ctl
);
  import tcpu_pkg::*;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DEST,
    ST_DPTR,
    ST_DDATA,
    ST_SRC,
    ST_SPTR,
    ST_SDATA,
    ST_EXEC,
    ST_DIV,
    ST_DFIX,
    ST_RESULT
  } state_t;

  state_t state_r, state_nxt;

  // State register; reset starts the memory clearing pass.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = (state_r == ST_IDLE);

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    unique case (state_r)
      ST_CLEAR: begin
        ctl.clr_we = 1'b1;
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          ctl.load_item = 1'b1;
          state_nxt     = ST_DEST;
        end
      end
      ST_DEST: begin
        if (sts.is_branch) begin
          state_nxt = ST_RESULT;
        end else if (sts.dkind == DK_REG) begin
          ctl.dval_ld_reg = 1'b1;
          state_nxt       = ST_SRC;
        end else if (sts.daddr_bad) begin
          ctl.err_set  = 1'b1;
          ctl.err_code = ERR_ADDR;
          state_nxt    = ST_RESULT;
        end else begin
          ctl.rd_en  = 1'b1;
          ctl.rd_sel = RD_DADDR;
          if (sts.dkind == DK_DIR) begin
            ctl.dloc_ld_daddr = 1'b1;
            state_nxt         = ST_DDATA;
          end else begin
            state_nxt = ST_DPTR;
          end
        end
      end
      ST_DPTR: begin
        if (sts.ptr_bad) begin
          ctl.err_set  = 1'b1;
          ctl.err_code = ERR_ADDR;
          state_nxt    = ST_RESULT;
        end else begin
          ctl.rd_en       = 1'b1;
          ctl.rd_sel      = RD_PTR;
          ctl.dloc_ld_ptr = 1'b1;
          state_nxt       = ST_DDATA;
        end
      end
      ST_DDATA: begin
        ctl.dval_ld_mem = 1'b1;
        state_nxt       = ST_SRC;
      end
      ST_SRC: begin
        if (sts.is_xor) begin
          state_nxt = ST_EXEC;
        end else begin
          unique case (sts.skind) inside
            SK_IMM, SK_REG: begin
              ctl.sval_ld_src = 1'b1;
              state_nxt       = ST_EXEC;
            end
            default: begin
              if (sts.saddr_bad) begin
                ctl.err_set  = 1'b1;
                ctl.err_code = ERR_ADDR;
                state_nxt    = ST_RESULT;
              end else begin
                ctl.rd_en  = 1'b1;
                ctl.rd_sel = RD_SADDR;
                state_nxt  = (sts.skind == SK_IND) ? ST_SPTR : ST_SDATA;
              end
            end
          endcase
        end
      end
      ST_SPTR: begin
        if (sts.ptr_bad) begin
          ctl.err_set  = 1'b1;
          ctl.err_code = ERR_ADDR;
          state_nxt    = ST_RESULT;
        end else begin
          ctl.rd_en  = 1'b1;
          ctl.rd_sel = RD_PTR;
          state_nxt  = ST_SDATA;
        end
      end
      ST_SDATA: begin
        ctl.sval_ld_mem = 1'b1;
        state_nxt       = ST_EXEC;
      end
      ST_EXEC: begin
        if (!sts.is_div) begin
          ctl.alu_go = 1'b1;
          state_nxt  = ST_RESULT;
        end else if (sts.src_zero) begin
          ctl.err_set  = 1'b1;
          ctl.err_code = ERR_DIV0;
          state_nxt    = ST_RESULT;
        end else begin
          ctl.div_start = 1'b1;
          state_nxt     = ST_DIV;
        end
      end
      ST_DIV: begin
        ctl.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_DFIX;
        end
      end
      ST_DFIX: begin
        ctl.div_fix = 1'b1;
        state_nxt   = ST_RESULT;
      end
      ST_RESULT: begin
        if (sts.out_free) begin
          ctl.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- hw/rtl/tcpu_dpath.sv -----
// Datapath: instruction register, register file, data memory, ALU, divider, output.
`timescale 1ns / 1ps
`default_nettype none
module tcpu_dpath #(
  parameter int MEM_WORDS = tcpu_pkg::MEM_WORDS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire tcpu_pkg::ctl_t                     ctl,
  output tcpu_pkg::sts_t                          sts,
  input  wire logic [tcpu_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  wire logic                               out_tready,
  output logic                                    out_tvalid,
  output logic      [tcpu_pkg::OUT_TDATA_W-1:0]   out_tdata
);
  import tcpu_pkg::*;

  localparam int         MemAw   = $clog2(MEM_WORDS);
  localparam logic [16:0] MemLim = 17'(MEM_WORDS);
  localparam int         DivCntW = $clog2(DATA_W);

  // Instruction fields.
  logic [3:0]        cmd_r;
  logic [1:0]        dkind_r;
  logic [1:0]        dreg_r;
  logic [10:0]       daddr_r;
  logic [1:0]        skind_r;
  logic [1:0]        sreg_r;
  logic [10:0]       saddr_r;
  logic [7:0]        simm_r;

  // Architectural state and working registers.
  logic [DATA_W-1:0] gpr_r [4];
  logic [DATA_W-1:0] last_r;
  logic [MemAw-1:0]  clr_cnt_r;
  logic [1:0]        err_r;
  logic [DATA_W-1:0] dval_r;
  logic [DATA_W-1:0] sval_r;
  logic [MemAw-1:0]  dloc_r;
  logic [DATA_W-1:0] nval_r;
  logic [DATA_W-1:0] remv_r;
  logic              out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  // Divider registers.
  logic [DATA_W-1:0]  dq_r;
  logic [DATA_W-1:0]  dr_r;
  logic [DATA_W-1:0]  ub_r;
  logic               qneg_r;
  logic               rneg_r;
  logic [DivCntW-1:0] dcnt_r;

  logic [DATA_W-1:0] ram_rdata;
  logic [MemAw-1:0]  ram_raddr;
  logic              ram_we;
  logic [MemAw-1:0]  ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [DATA_W-1:0] rf_rdata;
  logic [DATA_W-1:0] imm_ext;
  logic [DATA_W-1:0] alu_res;
  logic [DATA_W:0]   div_sh;
  logic              div_ge;
  logic [DATA_W:0]   div_diff;
  logic              is_branch;
  logic              is_div;
  logic              do_write;
  logic              rem_to_dest;
  logic              taken;
  logic [DATA_W-1:0] res_value;

  // Instruction register loads on the accepted transaction.
  always_ff @(posedge clk) begin
    if (ctl.load_item) begin
      cmd_r   <= in_tdata[3:0];
      dkind_r <= in_tdata[5:4];
      dreg_r  <= in_tdata[7:6];
      daddr_r <= in_tdata[18:8];
      skind_r <= in_tdata[20:19];
      sreg_r  <= in_tdata[22:21];
      saddr_r <= in_tdata[33:23];
      simm_r  <= in_tdata[41:34];
    end
  end

  assign is_branch = cmd_r[3];
  assign is_div    = (cmd_r == CMD_DIV);
  assign imm_ext   = {{(DATA_W-8){simm_r[7]}}, simm_r};

  // Register file has a single read port shared by destination and source.
  assign rf_rdata = gpr_r[ctl.sval_ld_src ? sreg_r : dreg_r];

  // Data memory read address.
  always_comb begin
    unique case (ctl.rd_sel)
      RD_DADDR: ram_raddr = MemAw'(daddr_r);
      RD_SADDR: ram_raddr = MemAw'(saddr_r);
      RD_PTR:   ram_raddr = MemAw'(ram_rdata);
      default:  ram_raddr = '0;
    endcase
  end

  // Memory writes come from the clearing pass or from write-back.
  assign do_write  = !is_branch && (err_r == ERR_OK);
  assign ram_we    = ctl.clr_we || (ctl.commit && do_write && (dkind_r != DK_REG));
  assign ram_waddr = ctl.clr_we ? clr_cnt_r : dloc_r;
  assign ram_wdata = ctl.clr_we ? '0 : nval_r;

  tcpu_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MEM_WORDS)
  ) u_mem (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ctl.rd_en),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Clearing pass address counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (ctl.clr_we) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  // Operand capture, error flag and destination location.
  always_ff @(posedge clk) begin
    if (ctl.dval_ld_reg) begin
      dval_r <= rf_rdata;
    end else if (ctl.dval_ld_mem) begin
      dval_r <= ram_rdata;
    end
    if (ctl.sval_ld_src) begin
      sval_r <= (skind_r == SK_IMM) ? imm_ext : rf_rdata;
    end else if (ctl.sval_ld_mem) begin
      sval_r <= ram_rdata;
    end
    if (ctl.dloc_ld_daddr) begin
      dloc_r <= MemAw'(daddr_r);
    end else if (ctl.dloc_ld_ptr) begin
      dloc_r <= MemAw'(ram_rdata);
    end
    if (ctl.load_item) begin
      err_r <= ERR_OK;
    end else if (ctl.err_set) begin
      err_r <= ctl.err_code;
    end
  end

  // Combinational operations; the result, the product included, is registered in nval_r.
  always_comb begin
    case (cmd_r)
      CMD_MOV: alu_res = sval_r;
      CMD_ADD: alu_res = dval_r + sval_r;
      CMD_MUL: alu_res = DATA_W'(dval_r * sval_r);
      CMD_SUB: alu_res = dval_r - sval_r;
      CMD_AND: alu_res = dval_r & sval_r;
      CMD_OR:  alu_res = dval_r | sval_r;
      default: alu_res = dval_r ^ {{(DATA_W-8){1'b0}}, 8'hFF};
    endcase
  end

  // Restoring divider step on magnitudes, one quotient bit per cycle.
  assign div_sh   = {dr_r, dq_r[DATA_W-1]};
  assign div_ge   = (div_sh >= {1'b0, ub_r});
  assign div_diff = div_sh - {1'b0, ub_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dcnt_r <= '0;
    end else if (ctl.div_start) begin
      dcnt_r <= '0;
    end else if (ctl.div_step) begin
      dcnt_r <= dcnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.div_start) begin
      dq_r   <= dval_r[DATA_W-1] ? -dval_r : dval_r;
      ub_r   <= sval_r[DATA_W-1] ? -sval_r : sval_r;
      dr_r   <= '0;
      qneg_r <= dval_r[DATA_W-1] ^ sval_r[DATA_W-1];
      rneg_r <= dval_r[DATA_W-1];
    end else if (ctl.div_step) begin
      dr_r <= div_ge ? div_diff[DATA_W-1:0] : div_sh[DATA_W-1:0];
      dq_r <= {dq_r[DATA_W-2:0], div_ge};
    end
    // Quotient and remainder take the signs of truncating division.
    if (ctl.alu_go) begin
      nval_r <= alu_res;
    end else if (ctl.div_fix) begin
      nval_r <= qneg_r ? -dq_r : dq_r;
      remv_r <= rneg_r ? -dr_r : dr_r;
    end
  end

  // Branch condition on the last destination value.
  always_comb begin
    case (cmd_r)
      CMD_BZ:   taken = (last_r == '0);
      CMD_BNZ:  taken = (last_r != '0);
      CMD_BNEG: taken = last_r[DATA_W-1];
      CMD_BPOS: taken = !last_r[DATA_W-1] && (last_r != '0);
      default:  taken = 1'b0;
    endcase
  end

  // With a register destination of three, the remainder replaces the quotient.
  assign rem_to_dest = is_div && (dkind_r == DK_REG) && (dreg_r == 2'd3);
  assign res_value   = rem_to_dest ? remv_r : nval_r;

  // Write-back of registers and last destination value.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        gpr_r[i] <= '0;
      end
      last_r <= '0;
    end else if (ctl.commit && do_write) begin
      for (int i = 0; i < 4; i++) begin
        if ((dkind_r == DK_REG) && (dreg_r == 2'(i))) begin
          gpr_r[i] <= nval_r;
        end
      end
      if (is_div) begin
        gpr_r[3] <= remv_r;
      end
      last_r <= res_value;
    end
  end

  // Output register decouples the result from the downstream stall.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      if (is_branch) begin
        out_data_r <= {5'd0, ERR_OK, taken, last_r};
      end else if (err_r != ERR_OK) begin
        out_data_r <= {5'd0, err_r, 1'b0, {DATA_W{1'b0}}};
      end else begin
        out_data_r <= {5'd0, ERR_OK, 1'b0, res_value};
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Status to the controller.
  always_comb begin
    sts           = '0;
    sts.is_branch = is_branch;
    sts.is_xor    = (cmd_r == CMD_XOR);
    sts.is_div    = is_div;
    sts.dkind     = dkind_r;
    sts.skind     = skind_r;
    sts.daddr_bad = (17'(daddr_r) >= MemLim);
    sts.saddr_bad = (17'(saddr_r) >= MemLim);
    sts.ptr_bad   = (17'(ram_rdata) >= MemLim);
    sts.src_zero  = (sval_r == '0);
    sts.div_last  = (dcnt_r == DivCntW'(DATA_W-1));
    sts.clr_last  = (clr_cnt_r == MemAw'(MEM_WORDS-1));
    sts.out_free  = !out_valid_r || out_tready;
  end

endmodule
`default_nettype wire

// ----- hw/rtl/tcpu_checker.sv -----
// Port-level checker for the toy CPU execute unit and its bind.
`timescale 1ns / 1ps
`default_nettype none
module tcpu_checker (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             in_tvalid,
  input wire logic                             in_tready,
  input wire logic                             out_tvalid,
  input wire logic                             out_tready,
  input wire logic [tcpu_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import tcpu_pkg::*;

  // Reset empties the result register and starts the clearing pass.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !in_tready && !out_tvalid)
    else $error("ports active right after reset");

  // Only one instruction is in flight at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted on consecutive cycles");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // A failed instruction reports a zero value and no branch.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[18:17] != ERR_OK) |-> (out_tdata[16:0] == 17'd0))
    else $error("error result carries data");

  // Only defined error codes appear and padding stays zero.
  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[23:19] == 5'd0) &&
      (out_tdata[18:17] == ERR_OK || out_tdata[18:17] == ERR_ADDR ||
       out_tdata[18:17] == ERR_DIV0))
    else $error("bad error code or padding");

endmodule

bind toy_cpu_execute_unit tcpu_checker u_tcpu_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire

// ----- sim/testbench.sv -----
// Self-checking testbench for the toy CPU execute unit.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
  import tcpu_pkg::*;

  localparam int MEM_SIZE   = MEM_WORDS_DEF;
  localparam int WIN        = 16;        // small address window that random items favor
  localparam int RAND_ITEMS = 950;
  localparam int END_WAIT   = 40;
  localparam int LIMIT      = 600000;

  // Codes the package does not name.
  localparam logic [1:0] DK_IND_ALT = 2'd3;
  localparam logic [3:0] CMD_UNUSED = 4'd15;

  // One instruction, packed as on in_tdata (command in the lowest bits).
  typedef struct packed {
    logic [7:0]  imm;
    logic [10:0] saddr;
    logic [1:0]  sreg;
    logic [1:0]  skind;
    logic [10:0] daddr;
    logic [1:0]  dreg;
    logic [1:0]  dkind;
    logic [3:0]  cmd;
  } instr_t;

  // One result, packed as on out_tdata.
  typedef struct packed {
    logic [1:0]  err;
    logic        taken;
    logic [15:0] val;
  } result_t;

  // Directed stimulus row; a typed row carries its expected result.
  typedef struct packed {
    instr_t  ins;
    logic    typed;
    result_t res;
  } dir_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  // Typed expectation that travels alongside the driven instruction.
  logic    typed_flag = 1'b0;
  result_t typed_res = '0;

  // Architectural state of the predictor.
  logic [15:0] gp_regs [4];
  logic [15:0] data_mem [MEM_SIZE];
  logic [15:0] last_dest;

  result_t    results_pending [$];
  dir_row_t   dir_rows [$];
  int         mismatches = 0;
  int         n_results = 0;
  int         burst_left = 0;

  toy_cpu_execute_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Executes one instruction on the predictor state and returns its result.
  function automatic result_t execute_instr(input instr_t i);
    result_t     r;
    logic [15:0] dval, sval, nval, remv, ptr;
    logic [1:0]  err;
    logic        rem_write;
    int          dloc, sloc, num, den;
    r = '0;
    err = ERR_OK;
    dval = '0;
    sval = '0;
    nval = '0;
    remv = '0;
    rem_write = 1'b0;
    dloc = 0;
    sloc = 0;

    // Branches and unused commands only report on the last destination value.
    if (i.cmd >= CMD_BZ) begin
      r.val = last_dest;
      case (i.cmd)
        CMD_BZ:   r.taken = (last_dest == 16'd0);
        CMD_BNZ:  r.taken = (last_dest != 16'd0);
        CMD_BNEG: r.taken = last_dest[15];
        CMD_BPOS: r.taken = !last_dest[15] && (last_dest != 16'd0);
        default:  r.taken = 1'b0;
      endcase
      return r;
    end

    // Destination operand; kinds two and three both go through a pointer.
    if (i.dkind == DK_REG) begin
      dval = gp_regs[i.dreg];
    end else begin
      dloc = int'(i.daddr);
      if (i.dkind != DK_DIR) begin
        ptr = data_mem[i.daddr];
        if (ptr >= MEM_SIZE) err = ERR_ADDR;
        else dloc = int'(ptr);
      end
      if (err == ERR_OK) dval = data_mem[dloc];
    end

    // Source operand, never fetched for the low byte complement.
    if (err == ERR_OK && i.cmd != CMD_XOR) begin
      case (i.skind)
        SK_IMM: sval = {{8{i.imm[7]}}, i.imm};
        SK_REG: sval = gp_regs[i.sreg];
        default: begin
          sloc = int'(i.saddr);
          if (i.skind == SK_IND) begin
            ptr = data_mem[i.saddr];
            if (ptr >= MEM_SIZE) err = ERR_ADDR;
            else sloc = int'(ptr);
          end
          if (err == ERR_OK) sval = data_mem[sloc];
        end
      endcase
    end

    if (err == ERR_OK) begin
      case (i.cmd)
        CMD_MOV: nval = sval;
        CMD_ADD: nval = dval + sval;
        CMD_MUL: nval = dval * sval;
        CMD_SUB: nval = dval - sval;
        CMD_DIV: begin
          num = int'($signed(dval));
          den = int'($signed(sval));
          if (den == 0) begin
            err = ERR_DIV0;
          end else begin
            nval = 16'(num / den);
            remv = 16'(num % den);
            rem_write = 1'b1;
          end
        end
        CMD_AND: nval = dval & sval;
        CMD_OR:  nval = dval | sval;
        default: nval = dval ^ 16'h00FF;
      endcase
    end

    // Commit; with register three as destination the remainder wins.
    if (err == ERR_OK) begin
      if (i.dkind == DK_REG) gp_regs[i.dreg] = nval;
      else data_mem[dloc] = nval;
      if (rem_write) gp_regs[3] = remv;
      if (i.dkind == DK_REG) nval = gp_regs[i.dreg];
      last_dest = nval;
      r.val = nval;
    end
    r.err = err;
    return r;
  endfunction

  function automatic instr_t ins(input logic [3:0] cmd, input logic [1:0] dk,
                                 input logic [1:0] dr, input logic [10:0] da,
                                 input logic [1:0] sk, input logic [1:0] sr,
                                 input logic [10:0] sa, input logic [7:0] imm);
    instr_t i;
    i.cmd = cmd;
    i.dkind = dk;
    i.dreg = dr;
    i.daddr = da;
    i.skind = sk;
    i.sreg = sr;
    i.saddr = sa;
    i.imm = imm;
    return i;
  endfunction

  function automatic result_t res_of(input logic [15:0] v, input logic t,
                                     input logic [1:0] e);
    result_t r;
    r.val = v;
    r.taken = t;
    r.err = e;
    return r;
  endfunction

  // Addresses mostly fall in a small window so that stored pointers get reused.
  function automatic logic [10:0] rand_addr();
    if ($urandom_range(0, 99) < 85) return 11'($urandom_range(0, WIN - 1));
    return 11'($urandom_range(0, MEM_SIZE - 1));
  endfunction

  // Random instruction: mostly well-formed operations, some pointer stores,
  // and some raw noise over every bit of every field.
  function automatic instr_t random_instr();
    instr_t      i;
    logic [63:0] raw;
    int          sel, pick;
    sel = $urandom_range(0, 99);
    raw = {$urandom(), $urandom()};
    i = raw[41:0];
    if (sel < 12) return i;
    i.dreg = 2'($urandom_range(0, 3));
    i.sreg = 2'($urandom_range(0, 3));
    i.daddr = rand_addr();
    i.saddr = rand_addr();
    if (sel < 27) begin
      // Store a small pointer value into the window.
      i.cmd = CMD_MOV;
      i.dkind = DK_DIR;
      if ($urandom_range(0, 3) != 0) begin
        i.skind = SK_IMM;
        i.imm = 8'($urandom_range(0, WIN - 1));
      end else begin
        i.skind = SK_REG;
      end
      return i;
    end
    pick = $urandom_range(0, 99);
    if (pick < 70) i.cmd = 4'($urandom_range(CMD_MOV, CMD_XOR));
    else if (pick < 95) i.cmd = 4'($urandom_range(CMD_BZ, CMD_BPOS));
    else i.cmd = 4'($urandom_range(CMD_BPOS + 1, CMD_UNUSED));
    pick = $urandom_range(0, 99);
    if (pick < 40) i.dkind = DK_REG;
    else if (pick < 65) i.dkind = DK_DIR;
    else if (pick < 95) i.dkind = DK_IND;
    else i.dkind = DK_IND_ALT;
    i.skind = 2'($urandom_range(SK_IMM, SK_IND));
    return i;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("Mismatch on %s at result %0d: got %h, expected %h",
             what, n_results, got, want);
    mismatches++;
  endtask

  // Sends one transaction, then closes the burst with a random gap if due.
  task automatic send_instr(input instr_t i, input logic typed, input result_t r);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata <= {{(IN_TDATA_W - $bits(instr_t)){1'b0}}, i};
    typed_flag <= typed;
    typed_res <= r;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 12);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Holds off the sender until every expected result has come back.
  task automatic wait_drained();
    @(posedge clk);
    while (results_pending.size() != 0) @(posedge clk);
  endtask

  // Predicts each accepted instruction and checks each accepted result.
  always @(posedge clk) begin : track_p
    result_t predicted, got, want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        predicted = execute_instr(in_tdata[$bits(instr_t)-1:0]);
        results_pending.push_back(typed_flag ? typed_res : predicted);
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata[$bits(result_t)-1:0];
        n_results++;
        if (results_pending.size() == 0) begin
          report_mismatch("unexpected result", got.val, 16'd0);
        end else begin
          want = results_pending.pop_front();
          if (got.val !== want.val) report_mismatch("result_value", got.val, want.val);
          if (got.taken !== want.taken)
            report_mismatch("branch_taken", 16'(got.taken), 16'(want.taken));
          if (got.err !== want.err)
            report_mismatch("error_code", 16'(got.err), 16'(want.err));
        end
      end
    end
  end

  // Result side stalls on its own pattern, switching style now and then.
  always @(posedge clk) begin : ready_p
    int       ready_cnt;
    logic [1:0] mode;
    ready_cnt++;
    if (ready_cnt % 300 == 0) mode = 2'($urandom_range(0, 3));
    case (mode)
      2'd0:    out_tready <= 1'b1;
      2'd1:    out_tready <= 1'($urandom_range(0, 1));
      2'd2:    out_tready <= ($urandom_range(0, 3) == 0);
      default: out_tready <= ((ready_cnt % 7) < 3);
    endcase
  end

  // Ends the run if it hangs.
  always @(posedge clk) begin : watchdog_p
    int cycles;
    cycles++;
    if (cycles >= LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Main sequence: reset, directed table, random items, final verdict.
  initial begin
    foreach (gp_regs[k]) gp_regs[k] = '0;
    foreach (data_mem[k]) data_mem[k] = '0;
    last_dest = '0;

    // Branches right after reset, then the basic operations.
    dir_rows.push_back({ins(CMD_BZ, DK_REG, 0, 0, SK_IMM, 0, 0, 0), 1'b1,
                        res_of(16'd0, 1'b1, ERR_OK)});
    dir_rows.push_back({ins(CMD_BNZ, DK_REG, 0, 0, SK_IMM, 0, 0, 0), 1'b1,
                        res_of(16'd0, 1'b0, ERR_OK)});
    dir_rows.push_back({ins(CMD_BNEG, DK_REG, 0, 0, SK_IMM, 0, 0, 0), 1'b1,
                        res_of(16'd0, 1'b0, ERR_OK)});
    dir_rows.push_back({ins(CMD_BPOS, DK_REG, 0, 0, SK_IMM, 0, 0, 0), 1'b1,
                        res_of(16'd0, 1'b0, ERR_OK)});
    dir_rows.push_back({ins(CMD_MOV, DK_REG, 0, 0, SK_IMM, 0, 0, 8'h7F), 1'b1,
                        res_of(16'd127, 1'b0, ERR_OK)});
    dir_rows.push_back({ins(CMD_MOV, DK_REG, 1, 0, SK_IMM, 0, 0, 8'h80), 1'b1,
                        res_of(16'hFF80, 1'b0, ERR_OK)});
    dir_rows.push_back({ins(CMD_BNEG, DK_REG, 0, 0, SK_IMM, 0, 0, 0), 1'b1,
                        res_of(16'hFF80, 1'b1, ERR_OK)});
    dir_rows.push_back({ins(CMD_ADD, DK_REG, 0, 0, SK_REG, 1, 0, 0), 1'b0, result_t'('0)});
    dir_rows.push_back({ins(CMD_MOV, DK_DIR, 0, 11'd2047, SK_REG, 0, 0, 0), 1'b0,
                        result_t'('0)});
    dir_rows.push_back({ins(CMD_SUB, DK_REG, 2, 0, SK_DIR, 0, 11'd2047, 0), 1'b0,
                        result_t'('0)});
    // Zero divisor.
    dir_rows.push_back({ins(CMD_DIV, DK_REG, 0, 0, SK_IMM, 0, 0, 8'h00), 1'b1,
                        res_of(16'd0, 1'b0, ERR_DIV0)});
    // Word 5 becomes a pointer that is out of range.
    dir_rows.push_back({ins(CMD_MOV, DK_DIR, 0, 11'd5, SK_IMM, 0, 0, 8'hFF), 1'b0,
                        result_t'('0)});
    dir_rows.push_back({ins(CMD_ADD, DK_IND, 0, 11'd5, SK_IMM, 0, 0, 8'h01), 1'b1,
                        res_of(16'd0, 1'b0, ERR_ADDR)});
    // Destination fault wins over source fault and zero divisor.
    dir_rows.push_back({ins(CMD_DIV, DK_IND, 0, 11'd5, SK_IND, 0, 11'd5, 0), 1'b1,
                        res_of(16'd0, 1'b0, ERR_ADDR)});
    // Source fault wins over the divide.
    dir_rows.push_back({ins(CMD_DIV, DK_REG, 0, 0, SK_IND, 0, 11'd5, 0), 1'b1,
                        res_of(16'd0, 1'b0, ERR_ADDR)});
    // Valid pointer, indirect destination through the fourth kind code.
    dir_rows.push_back({ins(CMD_MOV, DK_DIR, 0, 11'd6, SK_IMM, 0, 0, 8'd10), 1'b0,
                        result_t'('0)});
    dir_rows.push_back({ins(CMD_OR, DK_IND_ALT, 0, 11'd6, SK_IMM, 0, 0, 8'h55), 1'b0,
                        result_t'('0)});
    dir_rows.push_back({ins(CMD_AND, DK_REG, 1, 0, SK_IND, 0, 11'd6, 0), 1'b0,
                        result_t'('0)});
    // The complement ignores a faulty source.
    dir_rows.push_back({ins(CMD_XOR, DK_REG, 0, 0, SK_IND, 0, 11'd5, 0), 1'b0,
                        result_t'('0)});
    // Build the most negative value, then divide it by minus one.
    dir_rows.push_back({ins(CMD_MOV, DK_REG, 2, 0, SK_IMM, 0, 0, 8'h80), 1'b0,
                        result_t'('0)});
    dir_rows.push_back({ins(CMD_MUL, DK_REG, 2, 0, SK_IMM, 0, 0, 8'h80), 1'b0,
                        result_t'('0)});
    dir_rows.push_back({ins(CMD_ADD, DK_REG, 2, 0, SK_REG, 2, 0, 0), 1'b0, result_t'('0)});
    dir_rows.push_back({ins(CMD_DIV, DK_REG, 2, 0, SK_IMM, 0, 0, 8'hFF), 1'b0,
                        result_t'('0)});
    // Divide into register three: the remainder overwrites the quotient.
    dir_rows.push_back({ins(CMD_MOV, DK_REG, 3, 0, SK_IMM, 0, 0, 8'h9C), 1'b0,
                        result_t'('0)});
    dir_rows.push_back({ins(CMD_DIV, DK_REG, 3, 0, SK_IMM, 0, 0, 8'd7), 1'b0,
                        result_t'('0)});
    dir_rows.push_back({ins(CMD_UNUSED, DK_REG, 0, 0, SK_IMM, 0, 0, 0), 1'b0,
                        result_t'('0)});

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[k]) send_instr(dir_rows[k].ins, dir_rows[k].typed, dir_rows[k].res);

    for (int k = 0; k < RAND_ITEMS; k++) begin
      if (k == RAND_ITEMS / 2) begin
        in_tvalid <= 1'b0;
        wait_drained();
      end
      send_instr(random_instr(), 1'b0, result_t'('0));
    end
    in_tvalid <= 1'b0;

    wait_drained();
    repeat (END_WAIT) @(posedge clk);
    if (mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
`default_nettype wire
